// ----- rtl/fpba_pkg.sv -----
// Shared types and constants for the fit-policy block allocator.
// Used by rtl/fit_policy_block_allocator_core.sv and tb/tb_top.sv; no dependencies.
package fpba_pkg;

  localparam int NUM_BLOCKS_DEF = 8;
  localparam int AMOUNT_W       = 16;
  localparam int SLOT_W         = 3;
  localparam int MODE_W         = 2;
  localparam int COUNT_W        = 4;
  localparam int CFG_INDEX_W    = 1;
  localparam int CFG_DATA_W     = 4;

  // operation codes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // placement policies
  localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_FIT_MODE      = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCKS_IN_USE = 1'd1;

  localparam logic [MODE_W-1:0]  FIT_MODE_RST      = MODE_FIRST;
  localparam logic [COUNT_W-1:0] BLOCKS_IN_USE_RST = 4'd8;

  typedef struct packed {
    logic                op;
    logic [SLOT_W-1:0]   block_slot;
    logic [AMOUNT_W-1:0] amount;
  } in_word_t;

  typedef struct packed {
    logic                granted;
    logic [SLOT_W-1:0]   chosen_block;
    logic [AMOUNT_W-1:0] leftover;
  } out_word_t;

endpackage

// ----- rtl/fpba_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No package dependencies.
module fpba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/fit_policy_block_allocator_core.sv -----
// Top level of the fit-policy block allocator: request sequencer, scan datapath, config regs.
// Depends on fpba_pkg and fpba_ram.
//
//   channel   direction  handshake            word
//   in        into       in_valid / in_stall  fpba_pkg::in_word_t
//   out       out of     out_valid/out_stall  fpba_pkg::out_word_t
//   cfg       into       cfg_we               cfg_index, cfg_data
//
// A load word writes the block table directly.
// A request reads the table memory one block a cycle over the blocks searched; a further
// step evaluates the last entry, another closes the scan and one writes back; with nothing
// searched the scan closes at once.
// Reset (rst, synchronous) empties the result register and restores the config registers;
// the block table keeps whatever it held. in_stall is high while a request is in work; a
// stalled result holds the write-back step until the out side takes the waiting word.
module fit_policy_block_allocator_core #(
  parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  fpba_pkg::in_word_t                 in_word,
  output logic                               out_valid,
  input  logic                               out_stall,
  output fpba_pkg::out_word_t                out_word,
  input  logic                               cfg_we,
  input  logic [fpba_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [fpba_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int LW = (CW > fpba_pkg::COUNT_W) ? CW : fpba_pkg::COUNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                      state;
  logic [fpba_pkg::MODE_W-1:0]     fit_mode;
  logic [fpba_pkg::COUNT_W-1:0]    blocks_in_use;
  logic [LW-1:0]                   cnt;
  logic [LW-1:0]                   lim;
  logic [LW-1:0]                   lim_next;
  logic                            pend;
  logic [AW-1:0]                   pidx;
  logic [fpba_pkg::AMOUNT_W-1:0]   req_amount;
  logic                            found;
  logic [AW-1:0]                   pick;
  logic [fpba_pkg::AMOUNT_W-1:0]   best;

  logic                            in_accept;
  logic                            load_ok;
  logic                            fin_go;
  logic                            issue;
  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [fpba_pkg::AMOUNT_W-1:0]   ram_wdata;
  logic [AW-1:0]                   ram_raddr;
  logic [fpba_pkg::AMOUNT_W-1:0]   ram_rdata;
  logic                            fits;
  logic [fpba_pkg::AMOUNT_W-1:0]   left;
  logic                            take;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign load_ok   = (int'(in_word.block_slot) < NUM_BLOCKS);
  assign fin_go    = (state == ST_FIN) && (!out_valid || !out_stall);
  assign issue     = (state == ST_SCAN) && (cnt < lim);

  // searched block count; an unknown policy searches nothing
  always_comb begin
    if (fit_mode != fpba_pkg::MODE_FIRST && fit_mode != fpba_pkg::MODE_BEST &&
        fit_mode != fpba_pkg::MODE_WORST) begin
      lim_next = '0;
    end else if (int'(blocks_in_use) > NUM_BLOCKS) begin
      lim_next = LW'(NUM_BLOCKS);
    end else begin
      lim_next = LW'(blocks_in_use);
    end
  end

  always_comb begin
    if (state == ST_FIN) begin
      ram_we    = fin_go && found;
      ram_waddr = pick;
      ram_wdata = best;
    end else begin
      ram_we    = in_accept && (in_word.op == fpba_pkg::OP_LOAD) && load_ok;
      ram_waddr = AW'(in_word.block_slot);
      ram_wdata = in_word.amount;
    end
  end

  assign ram_raddr = cnt[AW-1:0];

  fpba_ram #(
    .WIDTH (fpba_pkg::AMOUNT_W),
    .DEPTH (NUM_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // evaluate the entry that came back from the table this cycle
  assign fits = pend && (ram_rdata != '0) && (req_amount <= ram_rdata);
  assign left = ram_rdata - req_amount;

  always_comb begin
    take = 1'b0;
    if (fits) begin
      if (!found) begin
        take = 1'b1;
      end else if (fit_mode == fpba_pkg::MODE_BEST) begin
        take = (left < best);
      end else if (fit_mode == fpba_pkg::MODE_WORST) begin
        take = (left > best);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fit_mode      <= fpba_pkg::FIT_MODE_RST;
      blocks_in_use <= fpba_pkg::BLOCKS_IN_USE_RST;
      out_valid     <= 1'b0;
      pend          <= 1'b0;
      found         <= 1'b0;
      cnt           <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fpba_pkg::REG_FIT_MODE:      fit_mode      <= cfg_data[fpba_pkg::MODE_W-1:0];
          fpba_pkg::REG_BLOCKS_IN_USE: blocks_in_use <= cfg_data[fpba_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end

      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_accept && (in_word.op == fpba_pkg::OP_REQUEST)) begin
            state      <= ST_SCAN;
            req_amount <= in_word.amount;
            lim        <= lim_next;
            cnt        <= '0;
            pend       <= 1'b0;
            found      <= 1'b0;
          end
        end
        ST_SCAN: begin
          pend <= issue;
          if (issue) begin
            pidx <= cnt[AW-1:0];
            cnt  <= cnt + 1'b1;
          end
          if (take) begin
            found <= 1'b1;
            pick  <= pidx;
            best  <= left;
          end
          if (!issue && !pend) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          // write back the chosen block and post the result
          if (fin_go) begin
            if (found) begin
              out_word.granted      <= 1'b1;
              out_word.chosen_block <= fpba_pkg::SLOT_W'(pick);
              out_word.leftover     <= best;
            end else begin
              out_word.granted      <= 1'b0;
              out_word.chosen_block <= '0;
              out_word.leftover     <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for fit_policy_block_allocator_core: a directed table, then random
// phases over every placement policy and chosen search counts, scored by a behavioral allocator.
// Depends on fpba_pkg and the core RTL.
module tb_top;
  import fpba_pkg::*;

  localparam int NB             = NUM_BLOCKS_DEF;
  localparam int IDLE_LIMIT     = 4000;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int SETTLE_CYCLES  = NB + 6;
  localparam int PHASES         = 10;
  localparam int PHASE_WORDS    = 40;

  // policy code with no meaning; every request is refused
  localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

  typedef struct {
    bit                     is_cfg;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  val;
    in_word_t               w;
    bit                     typed;
    out_word_t              want;
  } plan_row_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_word_t               in_word   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_word_t              out_word;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // allocator state as the bench sees it
  logic [AMOUNT_W-1:0] blk_left [NB] = '{default: '0};
  logic [MODE_W-1:0]   pol_mode = FIT_MODE_RST;
  logic [COUNT_W-1:0]  scan_cnt = BLOCKS_IN_USE_RST;
  out_word_t           grant_q [$];
  out_word_t           head_res;

  plan_row_t plan [$];

  logic [MODE_W-1:0] ph_mode [PHASES] = '{MODE_FIRST, MODE_BEST, MODE_WORST, MODE_FIRST,
                                          MODE_BEST, MODE_WORST, MODE_NONE, MODE_BEST,
                                          MODE_WORST, MODE_FIRST};
  int ph_count [PHASES] = '{8, 8, 8, 1, 15, 0, 8, 4, 2, 8};

  int n_err     = 0;
  int n_words   = 0;
  int n_loads   = 0;
  int n_granted = 0;
  int n_refused = 0;
  int n_exact   = 0;
  int n_cfg     = 0;
  int idle_cnt  = 0;
  bit squeeze   = 1'b0;
  bit burst     = 1'b0;

  fit_policy_block_allocator_core #(.NUM_BLOCKS(NB)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one accepted word to the block table and work out its result, if any.
  task automatic fit_predict(input in_word_t w, output bit has_res, output out_word_t res);
    int lim;
    int j;
    int pick;
    bit hit;
    logic [AMOUNT_W-1:0] best;
    logic [AMOUNT_W-1:0] left;
    has_res = 1'b0;
    res     = '0;
    hit     = 1'b0;
    pick    = 0;
    best    = '0;
    if (w.op == OP_LOAD) begin
      blk_left[w.block_slot] = w.amount;
      n_loads++;
    end else begin
      lim = (scan_cnt > NB) ? NB : int'(scan_cnt);
      if (pol_mode != MODE_NONE) begin
        for (j = 0; j < lim && !(hit && pol_mode == MODE_FIRST); j++) begin
          if (blk_left[j] != '0 && w.amount <= blk_left[j]) begin
            left = blk_left[j] - w.amount;
            // strict compares keep ties on the lowest index
            if (!hit || (pol_mode == MODE_BEST && left < best) ||
                (pol_mode == MODE_WORST && left > best)) begin
              hit  = 1'b1;
              pick = j;
              best = left;
            end
          end
        end
      end
      has_res = 1'b1;
      if (hit) begin
        blk_left[pick]   = best;
        res.granted      = 1'b1;
        res.chosen_block = SLOT_W'(pick);
        res.leftover     = best;
        n_granted++;
        if (best == '0) n_exact++;
      end else begin
        n_refused++;
      end
    end
  endtask

  function automatic void add_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    r.w      = '0;
    r.typed  = 1'b0;
    r.want   = '0;
    plan.push_back(r);
  endfunction

  function automatic void add_word(logic op, int slot, int amt, bit typed = 1'b0,
                                   logic g = 1'b0, int blk = 0, int left = 0);
    plan_row_t r;
    r.is_cfg            = 1'b0;
    r.idx               = '0;
    r.val               = '0;
    r.w.op              = op;
    r.w.block_slot      = SLOT_W'(slot);
    r.w.amount          = AMOUNT_W'(amt);
    r.typed             = typed;
    r.want.granted      = g;
    r.want.chosen_block = SLOT_W'(blk);
    r.want.leftover     = AMOUNT_W'(left);
    plan.push_back(r);
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    int k;
    w.block_slot = SLOT_W'($urandom_range(0, NB - 1));
    k = $urandom_range(0, 9);
    if ($urandom_range(0, 99) < 30) begin
      w.op = OP_LOAD;
      case (k)
        0:       w.amount = '0;
        1:       w.amount = '1;
        2:       w.amount = AMOUNT_W'($urandom);
        3:       w.amount = blk_left[$urandom_range(0, NB - 1)];  // copy a size to make ties
        default: w.amount = AMOUNT_W'($urandom_range(1, 1500));
      endcase
    end else begin
      w.op = OP_REQUEST;
      case (k)
        0:       w.amount = '0;
        1:       w.amount = '1;
        2:       w.amount = AMOUNT_W'($urandom);
        3, 4:    w.amount = blk_left[$urandom_range(0, NB - 1)];  // aim for an exact fit
        default: w.amount = AMOUNT_W'($urandom_range(1, 600));
      endcase
    end
    return w;
  endfunction

  task automatic send(input in_word_t w, input bit typed, input out_word_t want);
    int gap;
    int r;
    bit has_res;
    out_word_t res;
    r = $urandom_range(0, 99);
    if (burst || r < 60) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 25);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    fit_predict(w, has_res, res);
    n_words++;
    if (has_res) grant_q.push_back(typed ? want : res);
  endtask

  // Drop valid, drain every result, then give a trailing load time to land.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_FIT_MODE) pol_mode = val[MODE_W-1:0];
    else scan_cnt = val;
    n_cfg++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (grant_q.size() == 0) begin
        n_err++;
        $display("%0t: result expected none actual granted=%0b block=%0d leftover=%0d",
                 $time, out_word.granted, out_word.chosen_block, out_word.leftover);
      end else begin
        head_res = grant_q.pop_front();
        if (out_word.granted !== head_res.granted) begin
          n_err++;
          $display("%0t: granted expected %0b actual %0b", $time, head_res.granted,
                   out_word.granted);
        end
        if (out_word.chosen_block !== head_res.chosen_block) begin
          n_err++;
          $display("%0t: chosen_block expected %0d actual %0d", $time,
                   head_res.chosen_block, out_word.chosen_block);
        end
        if (out_word.leftover !== head_res.leftover) begin
          n_err++;
          $display("%0t: leftover expected %0d actual %0d", $time, head_res.leftover,
                   out_word.leftover);
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) || cfg_we)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver back-pressure: open stretches, random stalls, long holds, one squeeze
  initial begin
    int pick;
    int len;
    int i;
    bit squeezed;
    squeezed = 1'b0;
    forever begin
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        repeat (SQUEEZE_CYCLES) @(negedge clk) out_stall <= 1'b1;
      end else begin
        pick = $urandom_range(0, 9);
        len  = (pick < 4) ? $urandom_range(10, 60) : $urandom_range(10, 40);
        for (i = 0; i < len; i++) begin
          @(negedge clk);
          if (pick < 4) out_stall <= 1'b0;
          else if (pick < 9) out_stall <= ($urandom_range(0, 2) == 0);
          else out_stall <= 1'b1;
        end
      end
    end
  end

  initial begin
    // fill every slot before the first request; the table is not cleared by reset
    add_word(OP_LOAD, 0, 100);
    add_word(OP_LOAD, 1, 500);
    add_word(OP_LOAD, 2, 200);
    add_word(OP_LOAD, 3, 300);
    add_word(OP_LOAD, 4, 600);
    add_word(OP_LOAD, 5, 0);
    add_word(OP_LOAD, 6, 65535);
    add_word(OP_LOAD, 7, 50);
    // zero request is granted the first nonzero block, which keeps its whole size
    add_word(OP_REQUEST, 5, 0, 1'b1, 1'b1, 0, 100);
    add_word(OP_REQUEST, 7, 65535, 1'b1, 1'b1, 6, 0);
    add_word(OP_REQUEST, 0, 65535, 1'b1, 1'b0, 0, 0);
    add_word(OP_REQUEST, 2, 150);
    add_cfg(REG_FIT_MODE, CFG_DATA_W'(MODE_BEST));
    add_word(OP_REQUEST, 0, 300);
    add_word(OP_REQUEST, 3, 60);
    add_cfg(REG_FIT_MODE, CFG_DATA_W'(MODE_WORST));
    add_word(OP_REQUEST, 0, 100);
    // blocks one and four now tie at 500
    add_word(OP_LOAD, 1, 500);
    add_word(OP_REQUEST, 6, 20);
    add_cfg(REG_BLOCKS_IN_USE, 4'd0);
    add_word(OP_REQUEST, 0, 1, 1'b1, 1'b0, 0, 0);
    add_cfg(REG_BLOCKS_IN_USE, 4'd15);
    add_word(OP_REQUEST, 1, 10);
    add_cfg(REG_FIT_MODE, CFG_DATA_W'(MODE_FIRST));
    add_cfg(REG_BLOCKS_IN_USE, 4'd1);
    add_word(OP_REQUEST, 0, 5);
    add_cfg(REG_FIT_MODE, CFG_DATA_W'(MODE_NONE));
    add_cfg(REG_BLOCKS_IN_USE, 4'd8);
    add_word(OP_REQUEST, 4, 0, 1'b1, 1'b0, 0, 0);

    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send(plan[i].w, plan[i].typed, plan[i].want);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(REG_FIT_MODE, CFG_DATA_W'(ph_mode[p]));
      write_reg(REG_BLOCKS_IN_USE, CFG_DATA_W'(ph_count[p]));
      burst = ($urandom_range(0, 3) == 0);
      if (p == 2) squeeze = 1'b1;
      repeat (PHASE_WORDS) send(rand_word(), 1'b0, '0);
    end
    settle();

    $display("Covered %0d words (%0d loads) and %0d register writes across all policies",
             n_words, n_loads, n_cfg);
    $display("Allocations: %0d granted, %0d exact fits, %0d refused; %0d mismatches",
             n_granted, n_exact, n_refused, n_err);
    if (n_err == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- fit_policy_block_allocator_core.f -----
rtl/fpba_pkg.sv
rtl/fpba_ram.sv
rtl/fit_policy_block_allocator_core.sv
tb/tb_top.sv
